FILE: rtl/odtt_pkg.sv
// Package of shared types and constants for the one-shot deadline timer table.
`timescale 1ns / 1ps
package odtt_pkg;

  // Number of timer slots in the cell chain.
  localparam int CAPACITY = 32;
  // Width of a slot index.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Width of a timer count, fixed by the active_count field.
  localparam int CNT_W = 6;

  // Value reported as the next delay when no timer is held.
  localparam logic [31:0] EMPTY_DELAY = 32'd1;

  // Item modes.
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  // One stored timer.
  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] tag;
  } entry_t;

  // Input beat.
  typedef struct packed {
    logic        mode;
    logic [31:0] now_seconds;
    logic [31:0] delay_seconds;
    logic [15:0] timer_tag;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic             kind;
    logic [15:0]      fired_tag;
    logic [31:0]      next_delay;
    logic             accepted;
    logic [CNT_W-1:0] active_count;
    logic             last;
  } result_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/odtt_cell.sv
// One slot of the timer chain: holds a timer and takes its neighbour's each shift.
`timescale 1ns / 1ps
module odtt_cell
  import odtt_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     upstream,
  input  entry_t     load_data,
  output entry_t     entry
);

  // A load wins over the shift; it places the recirculated head or a new timer.
  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      entry <= load_data;
    end else if (ctrl.shift_en) begin
      entry <= upstream;
    end
  end

endmodule

FILE: rtl/oneshot_deadline_timer_table_top.sv
// Top level of the one-shot deadline timer table: cell chain and its sequencer.
`timescale 1ns / 1ps
// The timers live in a chain of cells that shifts one slot towards the head per
// cycle while a pass runs. Every pass takes each held timer past the head once and
// writes each timer it keeps back at the tail, so table order is kept. An add
// stores the timer in the accept cycle and then makes one pass to find the nearest
// deadline. A tick makes one pass to count the due timers and a second one that
// fires and drops them. Results are shown for one cycle each on result, marked by
// strobe, and cannot be held off; the final beat of an item has last set and
// appears as busy falls. Table contents need no clearing after reset.
module oneshot_deadline_timer_table_top
  import odtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  in_item_t item,
  output logic     strobe,
  output result_t  result
);

  state_t state, state_next;

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] steps;
  logic [CNT_W-1:0] due_count;
  logic [CNT_W-1:0] final_len;
  logic             mode_q;
  logic [31:0]      now_q;
  logic             acc_q;
  logic             min_valid;
  logic [31:0]      min_val;

  entry_t     cells [CAPACITY];
  cell_ctrl_t ctrl  [CAPACITY];

  logic             shift_en;
  logic             load_any;
  logic [IDX_W-1:0] load_pos;
  entry_t           load_data;
  logic             strobe_next;
  result_t          result_next;

  logic   room;
  logic   head_match;
  logic   keep_head;
  entry_t head;

  assign busy       = (state != ST_IDLE);
  assign room       = (len < CNT_W'(CAPACITY));
  assign head       = cells[0];
  assign head_match = (head.deadline == now_q);
  assign keep_head  = !((mode_q == MODE_TICK) && head_match);

  // The chain of cells; the tail cell shifts in an empty entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t up;
    if (i == CAPACITY - 1) begin : g_tail
      assign up = '0;
    end else begin : g_mid
      assign up = cells[i + 1];
    end
    assign ctrl[i].shift_en = shift_en;
    assign ctrl[i].load_en  = load_any && (load_pos == IDX_W'(i));
    odtt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .upstream  (up),
      .load_data (load_data),
      .entry     (cells[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (item.mode == MODE_TICK) begin
            state_next = (len == '0) ? ST_FINISH : ST_COUNT;
          end else begin
            state_next = (room || (len != '0)) ? ST_WALK : ST_FINISH;
          end
        end
      end
      ST_COUNT: begin
        if (steps == CNT_W'(1)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (steps == CNT_W'(1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: chain control and the next result beat.
  always_comb begin
    shift_en    = 1'b0;
    load_any    = 1'b0;
    load_pos    = len[IDX_W-1:0] - IDX_W'(1);
    load_data   = head;
    strobe_next = 1'b0;
    result_next = '0;
    unique case (state)
      ST_IDLE: begin
        load_pos           = len[IDX_W-1:0];
        load_data.deadline = item.now_seconds + item.delay_seconds;
        load_data.tag      = item.timer_tag;
        load_any           = start && (item.mode == MODE_ADD) && room;
      end
      ST_COUNT: begin
        shift_en = 1'b1;
        load_any = 1'b1;
      end
      ST_WALK: begin
        shift_en = 1'b1;
        load_any = keep_head;
        if (!keep_head) begin
          strobe_next              = 1'b1;
          result_next.kind         = KIND_FIRED;
          result_next.fired_tag    = head.tag;
          result_next.active_count = final_len;
        end
      end
      ST_FINISH: begin
        strobe_next              = 1'b1;
        result_next.kind         = KIND_SCHED;
        result_next.next_delay   = min_valid ? (min_val - now_q) : EMPTY_DELAY;
        result_next.accepted     = acc_q;
        result_next.active_count = len;
        result_next.last         = 1'b1;
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      strobe    <= 1'b0;
      min_valid <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            min_valid <= 1'b0;
            if ((item.mode == MODE_ADD) && room) begin
              len <= len + CNT_W'(1);
            end
          end
        end
        ST_WALK: begin
          if (!keep_head) begin
            len <= len - CNT_W'(1);
          end else if (!min_valid || (head.deadline < min_val)) begin
            min_valid <= 1'b1;
          end
        end
        default: begin
          len <= len;
        end
      endcase
    end
  end

  // Pass counters and item registers.
  always_ff @(posedge clk) begin
    result <= result_next;
    unique case (state)
      ST_IDLE: begin
        mode_q    <= item.mode;
        now_q     <= item.now_seconds;
        acc_q     <= (item.mode == MODE_ADD) && room;
        due_count <= '0;
        if (item.mode == MODE_TICK) begin
          steps <= len;
        end else begin
          steps     <= len + (room ? CNT_W'(1) : CNT_W'(0));
          final_len <= len + (room ? CNT_W'(1) : CNT_W'(0));
        end
      end
      ST_COUNT: begin
        if (steps == CNT_W'(1)) begin
          steps     <= len;
          final_len <= len - (due_count + CNT_W'(head_match));
        end else begin
          steps     <= steps - CNT_W'(1);
          due_count <= due_count + CNT_W'(head_match);
        end
      end
      ST_WALK: begin
        steps <= steps - CNT_W'(1);
        if (keep_head && (!min_valid || (head.deadline < min_val))) begin
          min_val <= head.deadline;
        end
      end
      default: begin
        steps <= steps;
      end
    endcase
  end

endmodule

FILE: rtl/odtt_checker.sv
// Port-level checks of the timer table, bound to its top level.
`timescale 1ns / 1ps
module odtt_checker
  import odtt_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input in_item_t item,
  input logic     strobe,
  input result_t  result
);

  // The closing beat is a schedule result, and it is shown as the block frees up.
  a_last_is_sched: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> (result.kind == KIND_SCHED) && !busy)
    else $error("closing beat is not a schedule result or block still busy");

  // A fired beat never closes the item and comes while the item is still in work.
  a_fired_mid_item: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.kind == KIND_FIRED) |-> !result.last && busy && !result.accepted)
    else $error("fired beat out of place");

  // The reported count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.active_count <= CNT_W'(CAPACITY)))
    else $error("active count above capacity");

  // An accepted item always keeps the block busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

endmodule

bind oneshot_deadline_timer_table_top odtt_checker u_odtt_checker (.*);

FILE: dv/tb_oneshot_deadline_timer_table_top.sv
// Testbench for the one-shot deadline timer table: directed table, random beats and a predictor.
`timescale 1ns / 1ps
module tb_oneshot_deadline_timer_table_top;
  import odtt_pkg::*;

  localparam int RANDOM_ITEMS = 214;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  // One row of the directed table. Where typed is set, the schedule beat that
  // ends the item is the one written in the row rather than the predicted one.
  typedef struct {
    in_item_t    beat;
    bit          typed;
    logic [31:0] delay_exp;
    logic        acc_exp;
    logic [5:0]  count_exp;
  } stim_row_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  in_item_t item = '0;
  logic     busy;
  logic     strobe;
  result_t  result;

  // Typed expectation travelling alongside the item being offered.
  logic     row_typed = 1'b0;
  result_t  row_sched = '0;

  // Shadow of the timer table, updated on every accepted input beat.
  logic [31:0] shadow_deadline [CAPACITY];
  logic [15:0] shadow_tag [CAPACITY];
  int          shadow_count = 0;

  result_t     expected_beats [$];
  result_t     oldest_beat;
  stim_row_t   directed_rows [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          items_sent = 0;
  int          beats_checked = 0;
  int          fired_beats = 0;
  int          refused_adds = 0;

  oneshot_deadline_timer_table_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result beats of one accepted item and queue them.
  function automatic void predict_timer_item(in_item_t it);
    logic [15:0] fired_tags [$];
    logic [31:0] nearest;
    logic        stored;
    result_t     beat;
    int          keep;
    int          i;
    stored = 1'b0;
    keep = 0;
    if (it.mode == MODE_ADD) begin
      if (shadow_count < CAPACITY) begin
        shadow_deadline[shadow_count] = it.now_seconds + it.delay_seconds;
        shadow_tag[shadow_count] = it.timer_tag;
        shadow_count++;
        stored = 1'b1;
      end else begin
        refused_adds++;
      end
    end else begin
      // Drop due timers and close the gaps, keeping the order of the rest.
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_deadline[i] == it.now_seconds) begin
          fired_tags.push_back(shadow_tag[i]);
        end else begin
          shadow_deadline[keep] = shadow_deadline[i];
          shadow_tag[keep] = shadow_tag[i];
          keep++;
        end
      end
      shadow_count = keep;
    end
    foreach (fired_tags[i]) begin
      beat = '0;
      beat.kind = KIND_FIRED;
      beat.fired_tag = fired_tags[i];
      beat.active_count = shadow_count[CNT_W-1:0];
      expected_beats.push_back(beat);
    end
    // The nearest deadline is the smallest raw value, not relative to now.
    nearest = (shadow_count > 0) ? shadow_deadline[0] : '0;
    for (i = 1; i < shadow_count; i++) begin
      if (shadow_deadline[i] < nearest) nearest = shadow_deadline[i];
    end
    beat = '0;
    beat.kind = KIND_SCHED;
    beat.next_delay = (shadow_count == 0) ? EMPTY_DELAY : nearest - it.now_seconds;
    beat.accepted = stored;
    beat.active_count = shadow_count[CNT_W-1:0];
    beat.last = 1'b1;
    expected_beats.push_back(beat);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: mismatch on %s, expected %h, actual %h", $time, field, want, got);
    error_count++;
  endtask

  task automatic check_beat(result_t want, result_t got);
    if (got.kind !== want.kind)
      report_mismatch("kind", 32'(want.kind), 32'(got.kind));
    if (got.fired_tag !== want.fired_tag)
      report_mismatch("fired_tag", 32'(want.fired_tag), 32'(got.fired_tag));
    if (got.next_delay !== want.next_delay)
      report_mismatch("next_delay", want.next_delay, got.next_delay);
    if (got.accepted !== want.accepted)
      report_mismatch("accepted", 32'(want.accepted), 32'(got.accepted));
    if (got.active_count !== want.active_count)
      report_mismatch("active_count", 32'(want.active_count), 32'(got.active_count));
    if (got.last !== want.last)
      report_mismatch("last", 32'(want.last), 32'(got.last));
  endtask

  // Result checking and prediction, both on values sampled at the edge.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (strobe) begin
        beats_checked++;
        if (result.kind == KIND_FIRED) fired_beats++;
        if (expected_beats.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, actual %h", $time, result);
          error_count++;
        end else begin
          oldest_beat = expected_beats.pop_front();
          check_beat(oldest_beat, result);
        end
      end
      if (start && !busy) begin
        predict_timer_item(item);
        if (row_typed) expected_beats[expected_beats.size() - 1] = row_sched;
      end
      idle_cycles <= (strobe || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t ns: watchdog expired with %0d beats outstanding", $time,
             expected_beats.size());
    $display("tb: failure");
    $finish;
  end

  function automatic void add_row(logic mode, logic [31:0] now, logic [31:0] delay,
                                  logic [15:0] tag, bit typed, logic [31:0] delay_exp,
                                  logic acc_exp, logic [5:0] count_exp);
    stim_row_t row;
    row.beat.mode = mode;
    row.beat.now_seconds = now;
    row.beat.delay_seconds = delay;
    row.beat.timer_tag = tag;
    row.typed = typed;
    row.delay_exp = delay_exp;
    row.acc_exp = acc_exp;
    row.count_exp = count_exp;
    directed_rows.push_back(row);
  endfunction

  // Offer one beat, wait until it is taken, then maybe leave a gap.
  task automatic send_beat(in_item_t b, bit typed, result_t sched, bit allow_gap);
    item <= b;
    row_typed <= typed;
    row_sched <= sched;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (allow_gap && $urandom_range(0, 99) < 40) begin
      start <= 1'b0;
      row_typed <= 1'b0;
      if ($urandom_range(0, 9) < 8) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(20, 60)) @(posedge clk);
    end
  endtask

  // Stimulus: directed table, a full-table pass, then random beats.
  initial begin
    in_item_t    b;
    result_t     sched;
    logic [31:0] sim_now;
    logic [31:0] recent_deadlines [$];
    int          pick;
    int          idx;
    int          burst_left;
    int          k;

    // Empty table, single timer, wrap of now and deadline, several due at once.
    add_row(MODE_TICK, 32'd0, 32'd0, 16'h0000, 1'b1, EMPTY_DELAY, 1'b0, 6'd0);
    add_row(MODE_ADD, 32'd100, 32'd0, 16'hFFFF, 1'b1, 32'd0, 1'b1, 6'd1);
    add_row(MODE_TICK, 32'd99, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 32'd1, 1'b0, 6'd1);
    add_row(MODE_TICK, 32'd100, 32'd0, 16'h0000, 1'b1, EMPTY_DELAY, 1'b0, 6'd0);
    add_row(MODE_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0000, 1'b1, 32'hFFFFFFFF, 1'b1, 6'd1);
    add_row(MODE_ADD, 32'd0, 32'd5, 16'h0001, 1'b1, 32'd5, 1'b1, 6'd2);
    add_row(MODE_ADD, 32'd5, 32'd0, 16'h0002, 1'b1, 32'd0, 1'b1, 6'd3);
    add_row(MODE_ADD, 32'd3, 32'd2, 16'h5A5A, 1'b1, 32'd2, 1'b1, 6'd4);
    add_row(MODE_TICK, 32'd5, 32'd0, 16'h0000, 1'b1, 32'hFFFFFFF9, 1'b0, 6'd1);
    add_row(MODE_ADD, 32'hFFFFFFF0, 32'h20, 16'hA5A5, 1'b1, 32'h20, 1'b1, 6'd2);
    add_row(MODE_TICK, 32'hFFFFFFFE, 32'd0, 16'h0000, 1'b1, 32'h12, 1'b0, 6'd1);
    add_row(MODE_TICK, 32'h10, 32'd0, 16'h0000, 1'b1, EMPTY_DELAY, 1'b0, 6'd0);
    // Fill every slot with the same deadline, refuse one more, then fire them all.
    for (k = 0; k < CAPACITY; k++) begin
      add_row(MODE_ADD, 32'd1000 - 32'(k), 32'(k), 16'h0100 + 16'(k), 1'b0, '0, 1'b0, '0);
    end
    add_row(MODE_ADD, 32'd990, 32'd7, 16'hBEEF, 1'b1, 32'd10, 1'b0, 6'd32);
    add_row(MODE_TICK, 32'd1000, 32'd0, 16'h0000, 1'b1, EMPTY_DELAY, 1'b0, 6'd0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      sched = '0;
      sched.kind = KIND_SCHED;
      sched.next_delay = directed_rows[k].delay_exp;
      sched.accepted = directed_rows[k].acc_exp;
      sched.active_count = directed_rows[k].count_exp;
      sched.last = 1'b1;
      send_beat(directed_rows[k].beat, directed_rows[k].typed, sched, 1'b1);
    end

    // Hold off until the table has answered everything so far.
    start <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);

    // Random part: a running clock near the wrap point, short delays that come
    // due, long ones that pile up, and some noise on now.
    sim_now = 32'hFFFFFF80;
    burst_left = 0;
    sched = '0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
      end
      if (burst_left == 0 && $urandom_range(0, 29) == 0) burst_left = 15;
      b = '0;
      b.timer_tag = 16'($urandom());
      b.delay_seconds = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        b.mode = MODE_ADD;
        b.now_seconds = ($urandom_range(0, 9) == 0) ? $urandom() : sim_now;
        pick = $urandom_range(0, 9);
        if (pick < 7) b.delay_seconds = $urandom_range(0, 12);
        else if (pick == 7) b.delay_seconds = 32'hFFFFFFFF - $urandom_range(0, 3);
        recent_deadlines.push_back(b.now_seconds + b.delay_seconds);
        if (recent_deadlines.size() > 40) void'(recent_deadlines.pop_front());
      end else begin
        b.mode = MODE_TICK;
        if (pick < 80) begin
          b.now_seconds = sim_now;
          sim_now = sim_now + $urandom_range(0, 2);
        end else if (pick < 92 && recent_deadlines.size() > 0) begin
          idx = $urandom_range(0, recent_deadlines.size() - 1);
          b.now_seconds = recent_deadlines[idx];
          recent_deadlines.delete(idx);
        end else begin
          b.now_seconds = $urandom();
        end
      end
      if ($urandom_range(0, 49) == 0) sim_now = $urandom();
      send_beat(b, 1'b0, sched, burst_left == 0);
      if (burst_left > 0) burst_left--;
    end

    start <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed), checked %0d result beats.", items_sent,
             directed_rows.size(), beats_checked);
    $display("Timers fired: %0d, adds refused on a full table: %0d.", fired_beats,
             refused_adds);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
